FILE: hdl/ild_pkg.sv
// Shared constants, calibration table and types of the IR distance linearizer.
package ild_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int TABLE_ENTRIES = 13;
    localparam int MAX_WINDOW    = 16;

    localparam int WLEN_W = 5;
    localparam int NUM_W  = 16;
    localparam int OFS_W  = 8;
    localparam int CM_W   = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NUMERATOR = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = CFG_IDX_W'(2);

    localparam logic [WLEN_W-1:0] WLEN_RESET  = WLEN_W'(5);
    localparam logic [NUM_W-1:0]  NUMER_RESET = NUM_W'(61839);
    localparam logic [OFS_W-1:0]  OFS_RESET   = OFS_W'(9);

    localparam int SUM_W     = $clog2(MAX_WINDOW * ((1 << SAMPLE_BITS) - 1) + 1);
    localparam int WIN_W     = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W     = WIN_W;
    localparam int DIV_W     = (SUM_W > NUM_W) ? SUM_W : NUM_W;
    localparam int DIV_STEPS = (DIV_W + 1) / 2;
    localparam int QPAD_W    = 2 * DIV_STEPS;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int SEG_W     = $clog2(TABLE_ENTRIES);

    localparam int TABLE_BASE_CM = 10;
    localparam int TABLE_STEP_CM = 5;
    localparam int CM_MAX        = 255;
    localparam int FRAC_W        = $clog2(TABLE_STEP_CM + 1);
    localparam int NUMT_W        = SAMPLE_BITS + FRAC_W;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [SUM_W-1:0]       t_sum;
    typedef logic [WIN_W-1:0]       t_win;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [DIV_W-1:0]       t_div;
    typedef logic [NUM_W-1:0]       t_num;
    typedef logic [OFS_W-1:0]       t_ofs;
    typedef logic [CM_W-1:0]        t_cm;
    typedef logic [SEG_W-1:0]       t_seg;

    localparam t_sample CALIB [TABLE_ENTRIES] = '{
        t_sample'(3690), t_sample'(2602), t_sample'(2065), t_sample'(1731),
        t_sample'(1580), t_sample'(1424), t_sample'(1370), t_sample'(940),
        t_sample'(861),  t_sample'(782),  t_sample'(757),  t_sample'(685),
        t_sample'(650)
    };

    typedef struct packed {
        logic start;
        t_div dividend;
        t_div divisor;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_div quotient;
    } t_div_rsp;

    typedef struct packed {
        logic start;
        logic ack;
        t_sum sum;
        t_win win;
        t_num numerator;
        t_ofs offset;
    } t_lane_req;

    typedef struct packed {
        logic done;
        t_cm  distance;
        logic zero;
    } t_lane_rsp;

endpackage

FILE: hdl/ild_if.sv
// Handshake channel interfaces: sample requests, distance results, register writes.
interface ild_sample_if;
    logic                           valid;
    logic                           ready;
    logic [ild_pkg::SAMPLE_BITS-1:0] left_sample;
    logic [ild_pkg::SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface ild_result_if;
    logic                    valid;
    logic                    ready;
    logic [ild_pkg::CM_W-1:0] left_distance;
    logic [ild_pkg::CM_W-1:0] right_distance;
    logic                    zero_average;

    modport source (output valid, output left_distance, output right_distance,
                    output zero_average, input ready);
    modport sink   (input valid, input left_distance, input right_distance,
                    input zero_average, output ready);
endinterface

interface ild_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ild_pkg::CFG_IDX_W-1:0]  index;
    logic [ild_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/ir_distance_linearizer.sv
// Top level: window accumulation, register file, two channel lanes and result merge.
// Sample pairs that do not close a window are taken one per cycle. A pair that closes
// the window starts both channel lanes, and its distance result is loaded into the
// output register when both lanes are done and the output is free; the next
// window-closing pair is taken once the lanes have handed over. Each lane runs its
// divider, which yields two quotient bits per cycle, twice in series: first
// for the window average, then for the reciprocal formula, with the table
// interpolation done alongside the second division. A result waiting at the output
// does not stop further pairs from being accumulated.
module ir_distance_linearizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ild_sample_if.sink    i_sample,
    ild_result_if.source  o_result,
    ild_cfg_if.sink       i_cfg
);

    logic [ild_pkg::WLEN_W-1:0] r_wlen;
    ild_pkg::t_num              r_numer;
    ild_pkg::t_ofs              r_ofs;
    ild_pkg::t_sum              r_lsum, r_rsum;
    ild_pkg::t_cnt              r_cnt;
    logic                       r_busy;
    logic                       r_out_valid;
    ild_pkg::t_cm               r_out_l, r_out_r;
    logic                       r_out_z;

    ild_pkg::t_win      win_eff;
    ild_pkg::t_cnt      cnt_inc;
    ild_pkg::t_sum      lsum_inc, rsum_inc;
    logic               closes;
    logic               accept;
    logic               lane_ack;
    ild_pkg::t_lane_req left_req, right_req;
    ild_pkg::t_lane_rsp left_rsp, right_rsp;

    always_comb begin
        if (r_wlen == '0) begin
            win_eff = ild_pkg::WIN_W'(1);
        end else if (int'(r_wlen) > ild_pkg::MAX_WINDOW) begin
            win_eff = ild_pkg::WIN_W'(ild_pkg::MAX_WINDOW);
        end else begin
            win_eff = ild_pkg::WIN_W'(r_wlen);
        end
    end

    assign cnt_inc  = r_cnt + ild_pkg::CNT_W'(1);
    assign lsum_inc = r_lsum + ild_pkg::SUM_W'(i_sample.left_sample);
    assign rsum_inc = r_rsum + ild_pkg::SUM_W'(i_sample.right_sample);
    assign closes   = (cnt_inc >= win_eff);

    assign i_sample.ready = !r_busy || !closes;
    assign accept         = i_sample.valid && i_sample.ready;

    assign lane_ack = left_rsp.done && right_rsp.done && (!r_out_valid || o_result.ready);

    always_comb begin
        left_req.start     = accept && closes;
        left_req.ack       = lane_ack;
        left_req.sum       = lsum_inc;
        left_req.win       = win_eff;
        left_req.numerator = r_numer;
        left_req.offset    = r_ofs;
        right_req          = left_req;
        right_req.sum      = rsum_inc;
    end

    ild_lane u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (left_req),
        .o_rsp   (left_rsp)
    );

    ild_lane u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (right_req),
        .o_rsp   (right_rsp)
    );

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen  <= ild_pkg::WLEN_RESET;
            r_numer <= ild_pkg::NUMER_RESET;
            r_ofs   <= ild_pkg::OFS_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ild_pkg::REG_WINDOW:    r_wlen  <= i_cfg.data[ild_pkg::WLEN_W-1:0];
                ild_pkg::REG_NUMERATOR: r_numer <= i_cfg.data[ild_pkg::NUM_W-1:0];
                ild_pkg::REG_OFFSET:    r_ofs   <= i_cfg.data[ild_pkg::OFS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // accumulate, or clear and hand the window to the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsum <= '0;
            r_rsum <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b0;
        end else begin
            if (accept) begin
                if (closes) begin
                    r_lsum <= '0;
                    r_rsum <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_lsum <= lsum_inc;
                    r_rsum <= rsum_inc;
                    r_cnt  <= cnt_inc;
                end
            end
            if (accept && closes) begin
                r_busy <= 1'b1;
            end else if (lane_ack) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (lane_ack) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lane_ack) begin
            r_out_l <= left_rsp.distance;
            r_out_r <= right_rsp.distance;
            r_out_z <= left_rsp.zero | right_rsp.zero;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.left_distance  = r_out_l;
    assign o_result.right_distance = r_out_r;
    assign o_result.zero_average   = r_out_z;

    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        left_rsp.done == right_rsp.done)
        else $error("channel lanes finished in different cycles");

    a_done_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        left_rsp.done |-> r_busy)
        else $error("lane reports a result with no window outstanding");

    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        left_req.start |=> r_busy)
        else $error("window handed to lanes without marking busy");

    a_ack_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_ack |=> r_out_valid)
        else $error("lane result dropped at the output register");

    a_cnt_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < ild_pkg::CNT_W'(ild_pkg::MAX_WINDOW))
        else $error("stored sample count reached the window maximum");

endmodule

FILE: hdl/ild_div.sv
// Restoring unsigned divider, two quotient bits per cycle.
module ild_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ild_pkg::t_div_req i_req,
    output ild_pkg::t_div_rsp o_rsp
);

    logic                        r_run, n_run;
    logic                        r_done, n_done;
    logic [ild_pkg::STEP_W-1:0]  r_cnt, n_cnt;
    ild_pkg::t_div               r_rem, n_rem;
    ild_pkg::t_div               r_dsr, n_dsr;
    logic [ild_pkg::QPAD_W-1:0]  r_quo, n_quo;
    logic [ild_pkg::DIV_W:0]     rem_sh;

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_quo  = r_quo;
        rem_sh = '0;
        if (i_req.start) begin
            n_run = 1'b1;
            n_cnt = ild_pkg::STEP_W'(ild_pkg::DIV_STEPS - 1);
            n_rem = '0;
            n_dsr = i_req.divisor;
            n_quo = ild_pkg::QPAD_W'(i_req.dividend);
        end else if (r_run) begin
            for (int k = 0; k < 2; k++) begin
                rem_sh = {n_rem, n_quo[ild_pkg::QPAD_W-1]};
                n_quo  = {n_quo[ild_pkg::QPAD_W-2:0], 1'b0};
                if (rem_sh >= {1'b0, n_dsr}) begin
                    n_rem    = ild_pkg::DIV_W'(rem_sh - {1'b0, n_dsr});
                    n_quo[0] = 1'b1;
                end else begin
                    n_rem = rem_sh[ild_pkg::DIV_W-1:0];
                end
            end
            if (r_cnt == '0) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - ild_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dsr <= n_dsr;
        r_quo <= n_quo;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo[ild_pkg::DIV_W-1:0];

endmodule

FILE: hdl/ild_lane.sv
// One channel lane: window average, reciprocal formula and table interpolation.
module ild_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ild_pkg::t_lane_req i_req,
    output ild_pkg::t_lane_rsp o_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_AVG  = 3'd1;
    localparam logic [2:0] S_SEG  = 3'd2;
    localparam logic [2:0] S_FORM = 3'd3;
    localparam logic [2:0] S_HOLD = 3'd4;

    logic [2:0]        r_state, n_state;
    ild_pkg::t_sum     r_avg, n_avg;
    ild_pkg::t_seg     r_seg, n_seg;
    logic              r_above, n_above;
    logic              r_below, n_below;
    ild_pkg::t_cm      r_tab, n_tab;
    ild_pkg::t_cm      r_dist, n_dist;
    logic              r_zero, n_zero;

    ild_pkg::t_div_req div_req;
    ild_pkg::t_div_rsp div_rsp;

    ild_pkg::t_seg              seg;
    logic                       found;
    logic                       above;
    ild_pkg::t_seg              seg_lo;
    ild_pkg::t_sample           x1;
    ild_pkg::t_sample           x2;
    ild_pkg::t_sample           span;
    ild_pkg::t_sample           dx;
    logic [ild_pkg::NUMT_W-1:0] num;
    logic [ild_pkg::FRAC_W-1:0] frac;
    ild_pkg::t_cm               tab_cm;
    ild_pkg::t_cm               fcm;
    logic                       fzero;
    ild_pkg::t_div              dq;
    logic [ild_pkg::CM_W:0]     mean_sum;

    ild_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        if (r_state == S_IDLE) begin
            div_req.start    = i_req.start;
            div_req.dividend = ild_pkg::DIV_W'(i_req.sum);
            div_req.divisor  = ild_pkg::DIV_W'(i_req.win);
        end else begin
            div_req.start    = (r_state == S_SEG);
            div_req.dividend = ild_pkg::DIV_W'(i_req.numerator);
            div_req.divisor  = ild_pkg::DIV_W'(r_avg);
        end
    end

    // segment search over the falling calibration table
    always_comb begin
        seg   = '0;
        found = 1'b0;
        for (int j = ild_pkg::TABLE_ENTRIES - 1; j >= 1; j--) begin
            if (r_avg >= ild_pkg::SUM_W'(ild_pkg::CALIB[j])) begin
                seg   = ild_pkg::SEG_W'(j);
                found = 1'b1;
            end
        end
        above = (r_avg >= ild_pkg::SUM_W'(ild_pkg::CALIB[0]));
    end

    // interpolate inside the chosen segment
    always_comb begin
        seg_lo = (r_seg == '0) ? '0 : r_seg - ild_pkg::SEG_W'(1);
        x1     = ild_pkg::CALIB[seg_lo];
        x2     = ild_pkg::CALIB[r_seg];
        span   = x1 - x2;
        dx     = x1 - r_avg[ild_pkg::SAMPLE_BITS-1:0];
        num    = ild_pkg::NUMT_W'(dx) * ild_pkg::NUMT_W'(ild_pkg::TABLE_STEP_CM);
        frac   = '0;
        for (int k = 1; k <= ild_pkg::TABLE_STEP_CM; k++) begin
            if (span != '0 &&
                num >= ild_pkg::NUMT_W'(span) * ild_pkg::NUMT_W'(k)) begin
                frac = ild_pkg::FRAC_W'(k);
            end
        end
        if (r_above) begin
            tab_cm = ild_pkg::CM_W'(ild_pkg::TABLE_BASE_CM);
        end else if (r_below) begin
            tab_cm = ild_pkg::CM_W'(ild_pkg::TABLE_BASE_CM +
                                    ild_pkg::TABLE_STEP_CM * (ild_pkg::TABLE_ENTRIES - 1));
        end else begin
            tab_cm = ild_pkg::CM_W'(ild_pkg::TABLE_BASE_CM +
                                    ild_pkg::TABLE_STEP_CM * int'(seg_lo))
                     + ild_pkg::CM_W'(frac);
        end
    end

    // reciprocal formula and channel mean
    always_comb begin
        fzero = 1'b0;
        dq    = div_rsp.quotient - ild_pkg::DIV_W'(i_req.offset);
        if (r_avg == '0) begin
            fcm   = ild_pkg::CM_W'(ild_pkg::CM_MAX);
            fzero = 1'b1;
        end else if (div_rsp.quotient <= ild_pkg::DIV_W'(i_req.offset)) begin
            fcm = '0;
        end else if (dq > ild_pkg::DIV_W'(ild_pkg::CM_MAX)) begin
            fcm = ild_pkg::CM_W'(ild_pkg::CM_MAX);
        end else begin
            fcm = dq[ild_pkg::CM_W-1:0];
        end
        mean_sum = {1'b0, fcm} + {1'b0, r_tab};
    end

    always_comb begin
        n_state = r_state;
        n_avg   = r_avg;
        n_seg   = r_seg;
        n_above = r_above;
        n_below = r_below;
        n_tab   = r_tab;
        n_dist  = r_dist;
        n_zero  = r_zero;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_state = S_AVG;
                end
            end
            S_AVG: begin
                if (div_rsp.done) begin
                    n_avg   = div_rsp.quotient[ild_pkg::SUM_W-1:0];
                    n_state = S_SEG;
                end
            end
            S_SEG: begin
                n_seg   = seg;
                n_above = above;
                n_below = !above && !found;
                n_state = S_FORM;
            end
            S_FORM: begin
                n_tab = tab_cm;
                if (div_rsp.done) begin
                    n_dist  = mean_sum[ild_pkg::CM_W:1];
                    n_zero  = fzero;
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_req.ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_avg   <= n_avg;
        r_seg   <= n_seg;
        r_above <= n_above;
        r_below <= n_below;
        r_tab   <= n_tab;
        r_dist  <= n_dist;
        r_zero  <= n_zero;
    end

    assign o_rsp.done     = (r_state == S_HOLD);
    assign o_rsp.distance = r_dist;
    assign o_rsp.zero     = r_zero;

endmodule

FILE: tb/tb.sv
// Self-checking testbench of the IR distance linearizer: windowed samples in, distances out.
module tb;
    import ild_pkg::*;

    localparam int unsigned RANDOM_PAIRS  = 2000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned REPORT_MAX    = 10;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

    localparam int unsigned CAL_POINTS [13] = '{
        3690, 2602, 2065, 1731, 1580, 1424, 1370, 940, 861, 782, 757, 685, 650
    };

    typedef enum int {SMP_MIXED, SMP_LOW} t_sample_mode;
    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_COMB} t_ready_mode;

    typedef struct packed {
        t_cm  left;
        t_cm  right;
        logic zero;
    } t_distance;

    class t_distance_check;
        logic [WLEN_W-1:0] win_reg;
        logic [NUM_W-1:0]  num_reg;
        logic [OFS_W-1:0]  ofs_reg;
        int unsigned       left_acc;
        int unsigned       right_acc;
        int unsigned       taken;
        t_distance         due_distances [$];
        int unsigned       failures;
        int unsigned       pairs_seen;
        int unsigned       results_seen;
        int unsigned       zero_seen;
        int unsigned       writes_seen;

        function new();
            win_reg      = WLEN_RESET;
            num_reg      = NUMER_RESET;
            ofs_reg      = OFS_RESET;
            left_acc     = 0;
            right_acc    = 0;
            taken        = 0;
            failures     = 0;
            pairs_seen   = 0;
            results_seen = 0;
            zero_seen    = 0;
            writes_seen  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            writes_seen++;
            case (idx)
                REG_WINDOW:    win_reg = data[WLEN_W-1:0];
                REG_NUMERATOR: num_reg = data[NUM_W-1:0];
                REG_OFFSET:    ofs_reg = data[OFS_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned formula_dist(int unsigned avg, inout logic zero);
            int unsigned q;
            if (avg == 0) begin
                zero = 1'b1;
                return 255;
            end
            q = int'(num_reg) / avg;
            if (q <= int'(ofs_reg))
                return 0;
            q = q - int'(ofs_reg);
            return (q > 255) ? 255 : q;
        endfunction

        function int unsigned table_dist(int unsigned avg);
            if (avg >= CAL_POINTS[0])
                return 10;
            for (int j = 1; j < 13; j++) begin
                if (avg >= CAL_POINTS[j])
                    return 10 + 5 * (j - 1) +
                           ((CAL_POINTS[j-1] - avg) * 5) / (CAL_POINTS[j-1] - CAL_POINTS[j]);
            end
            return 70;
        endfunction

        function t_cm channel_dist(int unsigned avg, inout logic zero);
            int unsigned f;
            int unsigned t;
            f = formula_dist(avg, zero);
            t = table_dist(avg);
            return t_cm'((f + t) / 2);
        endfunction

        function void take_pair(t_sample l, t_sample r);
            int unsigned w;
            t_distance   d;
            logic        zero;
            pairs_seen++;
            w = (win_reg == 0) ? 1 : ((win_reg > 16) ? 16 : int'(win_reg));
            left_acc  += l;
            right_acc += r;
            taken++;
            if (taken < w)
                return;
            zero      = 1'b0;
            d.left    = channel_dist(left_acc / w, zero);
            d.right   = channel_dist(right_acc / w, zero);
            d.zero    = zero;
            left_acc  = 0;
            right_acc = 0;
            taken     = 0;
            due_distances.push_back(d);
        endfunction

        function void match_result(t_cm l, t_cm r, logic z);
            t_distance want;
            results_seen++;
            if (z === 1'b1)
                zero_seen++;
            if (due_distances.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected result: left %0d right %0d zero %0b", l, r, z);
                return;
            end
            want = due_distances.pop_front();
            if (want.left !== l || want.right !== r || want.zero !== z) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("result %0d: expected left %0d right %0d zero %0b, got %0d %0d %0b",
                             results_seen, want.left, want.right, want.zero, l, r, z);
            end
        endfunction

        function int unsigned outstanding();
            return due_distances.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int unsigned cycles;

    ild_sample_if smp ();
    ild_result_if res ();
    ild_cfg_if    cfg ();

    t_distance_check sb = new();

    ir_distance_linearizer DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp),
        .o_result (res),
        .i_cfg    (cfg)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.outstanding());
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready)
            sb.match_result(res.left_distance, res.right_distance, res.zero_average);
    end

    initial begin
        t_ready_mode mode;
        int unsigned span;
        int unsigned tick;
        res.ready <= 1'b0;
        mode = RDY_ALWAYS;
        span = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (span == 0) begin
                mode = t_ready_mode'($urandom_range(3));
                span = $urandom_range(400, 50);
            end
            span--;
            tick++;
            case (mode)
                RDY_ALWAYS: res.ready <= 1'b1;
                RDY_COIN:   res.ready <= ($urandom_range(1) == 1);
                RDY_SPARSE: res.ready <= ($urandom_range(3) == 0);
                default:    res.ready <= ((tick % 9) < 4);
            endcase
        end
    end

    task automatic send_pair(input t_sample l, input t_sample r);
        smp.valid        <= 1'b1;
        smp.left_sample  <= l;
        smp.right_sample <= r;
        @(posedge i_clk);
        while (!smp.ready) @(posedge i_clk);
        sb.take_pair(l, r);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        smp.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_sample pick_sample(t_sample_mode mode);
        int unsigned k;
        int          v;
        k = $urandom_range(99);
        if (mode == SMP_LOW)
            return ($urandom_range(2) == 0) ? t_sample'($urandom_range(3)) : t_sample'(0);
        if (k < 8)
            return t_sample'(0);
        if (k < 14)
            return t_sample'(4095);
        if (k < 55) begin
            v = int'(CAL_POINTS[$urandom_range(12)]) + int'($urandom_range(6)) - 3;
            return t_sample'(v);
        end
        return t_sample'($urandom_range(4095));
    endfunction

    task automatic pick_config();
        int unsigned k;
        if ($urandom_range(1) == 1) begin
            k = $urandom_range(9);
            case (k)
                0: write_reg(REG_WINDOW, 16'd0);
                1: write_reg(REG_WINDOW, 16'd16);
                2: write_reg(REG_WINDOW, 16'($urandom_range(31, 17)));
                3: write_reg(REG_WINDOW, 16'(($urandom() & 32'hFFE0) | $urandom_range(16, 1)));
                default: write_reg(REG_WINDOW, 16'($urandom_range(8, 1)));
            endcase
        end
        if ($urandom_range(2) == 0) begin
            k = $urandom_range(9);
            case (k)
                0: write_reg(REG_NUMERATOR, 16'd0);
                1: write_reg(REG_NUMERATOR, 16'hFFFF);
                2: write_reg(REG_NUMERATOR, 16'd1);
                3: write_reg(REG_NUMERATOR, 16'(NUMER_RESET));
                default: write_reg(REG_NUMERATOR, 16'($urandom_range(65535)));
            endcase
        end
        if ($urandom_range(2) == 0) begin
            k = $urandom_range(7);
            case (k)
                0: write_reg(REG_OFFSET, 16'd0);
                1: write_reg(REG_OFFSET, 16'd255);
                2: write_reg(REG_OFFSET, 16'($urandom()));
                default: write_reg(REG_OFFSET, 16'($urandom_range(40)));
            endcase
        end
    endtask

    initial begin
        int unsigned  random_sent;
        int unsigned  phase_len;
        int unsigned  burst;
        bit           gappy;
        t_sample_mode mode;

        i_rst_n          <= 1'b0;
        smp.valid        <= 1'b0;
        smp.left_sample  <= '0;
        smp.right_sample <= '0;
        cfg.valid        <= 1'b0;
        cfg.index        <= '0;
        cfg.data         <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every pair closes a window: zero, top, table ends and breakpoints
        write_reg(REG_WINDOW, 16'd1);
        send_pair(t_sample'(0), t_sample'(0));
        send_pair(t_sample'(4095), t_sample'(4095));
        send_pair(t_sample'(3690), t_sample'(650));
        send_pair(t_sample'(3689), t_sample'(649));
        send_pair(t_sample'(0), t_sample'(2602));
        drain_results();

        write_reg(REG_NUMERATOR, 16'd0);
        send_pair(t_sample'(1000), t_sample'(100));
        drain_results();

        write_reg(REG_NUMERATOR, 16'hFFFF);
        write_reg(REG_OFFSET, 16'd255);
        send_pair(t_sample'(1), t_sample'(255));
        drain_results();

        // window zero acts as one; the unused index is ignored
        write_reg(REG_OFFSET, 16'd0);
        write_reg(REG_WINDOW, 16'd0);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_pair(t_sample'(1), t_sample'(2));
        drain_results();

        // saturated window with full-scale sums
        write_reg(REG_WINDOW, 16'd31);
        repeat (16) send_pair(t_sample'(4095), t_sample'(4095));
        drain_results();

        // shorten the window mid-way
        write_reg(REG_NUMERATOR, 16'(NUMER_RESET));
        write_reg(REG_OFFSET, 16'(OFS_RESET));
        write_reg(REG_WINDOW, 16'd8);
        send_pair(t_sample'(1200), t_sample'(800));
        send_pair(t_sample'(1300), t_sample'(700));
        send_pair(t_sample'(1400), t_sample'(900));
        drain_results();
        write_reg(REG_WINDOW, 16'd2);
        send_pair(t_sample'(1500), t_sample'(2000));
        drain_results();

        random_sent = 0;
        while (random_sent < RANDOM_PAIRS) begin
            drain_results();
            pick_config();
            phase_len = $urandom_range(120, 10);
            gappy     = ($urandom_range(3) != 0);
            mode      = ($urandom_range(5) == 0) ? SMP_LOW : SMP_MIXED;
            burst     = $urandom_range(24, 1);
            repeat (phase_len) begin
                send_pair(pick_sample(mode), pick_sample(mode));
                random_sent++;
                if (gappy) begin
                    burst--;
                    if (burst == 0) begin
                        smp.valid <= 1'b0;
                        repeat ($urandom_range(15, 1)) @(posedge i_clk);
                        burst = $urandom_range(24, 1);
                    end
                end
            end
        end
        drain_results();

        $display("covered %0d sample pairs, %0d distance results (%0d with zero average)",
                 sb.pairs_seen, sb.results_seen, sb.zero_seen);
        $display("%0d register writes, %0d failures, %0d results outstanding",
                 sb.writes_seen, sb.failures, sb.outstanding());
        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

FILE: files.f
hdl/ild_pkg.sv
hdl/ild_if.sv
hdl/ild_div.sv
hdl/ild_lane.sv
hdl/ir_distance_linearizer.sv
tb/tb.sv
